>>> rtl/slxd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slxd_pkg
// Shared codes and types for the sync/length/xor deframer.
// ----------------------------------------------------------------------------
package slxd_pkg;

  localparam logic [7:0] SyncReset = 8'hAA;

  localparam logic [1:0] PhHunt  = 2'd0;
  localparam logic [1:0] PhLen   = 2'd1;
  localparam logic [1:0] PhData  = 2'd2;
  localparam logic [1:0] PhCheck = 2'd3;

  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindGood    = 2'd1;
  localparam logic [1:0] KindParity  = 2'd2;
  localparam logic [1:0] KindZero    = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] payload_count;
    logic [7:0] parity_errors;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/sync_length_xor_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_xor_deframer
// Byte stream deframer with sync byte, length byte and xor check byte.
// ----------------------------------------------------------------------------
// One received byte per beat. Each byte passes an input register, the frame
// state logic and a result register, and a new byte is taken every cycle
// while the result register can move. Payload
// bytes come out as kind 0 beats; the check byte gives a good or parity error
// verdict with the payload count and running error count, and a zero length
// byte gives a zero length verdict. Hunt, sync and nonzero length bytes give no beat.
module sync_length_xor_deframer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic [7:0]      payload_count_o,
  output logic [7:0]      parity_errors_o
);
  import slxd_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       free;
  logic       take;
  logic       res_valid;
  res_t       res;

  assign take = in_valid && free;

  slxd_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .take_i     (take),
    .valid_o    (in_valid),
    .byte_o     (in_byte)
  );

  slxd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (take),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  slxd_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .res_valid_i     (res_valid),
    .res_i           (res),
    .free_o          (free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .payload_count_o (payload_count_o),
    .parity_errors_o (parity_errors_o)
  );

endmodule
`default_nettype wire

>>> rtl/slxd_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slxd_in_stage
// Input register: holds one received byte until the core takes it.
// ----------------------------------------------------------------------------
module slxd_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      byte_d  = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule
`default_nettype wire

>>> rtl/slxd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slxd_core
// Frame state machine: sync hunt, length, payload xor and check verdict.
// ----------------------------------------------------------------------------
module slxd_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i,
  input  wire logic          fire_i,
  input  wire logic [7:0]    byte_i,
  output logic               res_valid_o,
  output slxd_pkg::res_t     res_o
);
  import slxd_pkg::*;

  logic [7:0] sync_q;
  logic [1:0] phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic [7:0] xor_q, xor_d;
  logic [7:0] len_q, len_d;
  logic [7:0] errs_q, errs_d;
  logic [7:0] left_dec;

  always_comb begin
    phase_d     = phase_q;
    left_d      = left_q;
    xor_d       = xor_q;
    len_d       = len_q;
    errs_d      = errs_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    left_dec    = (left_q != 8'd0) ? left_q - 8'd1 : left_q;
    if (fire_i) begin
      unique case (phase_q)
        PhHunt: begin
          if (byte_i == sync_q) begin
            phase_d = PhLen;
          end
        end
        PhLen: begin
          xor_d = 8'd0;
          if (byte_i == 8'd0) begin
            len_d       = 8'd0;
            left_d      = 8'd0;
            phase_d     = PhHunt;
            res_valid_o = 1'b1;
            res_o.kind  = KindZero;
          end else begin
            len_d   = byte_i - 8'd1;
            left_d  = byte_i - 8'd1;
            phase_d = (byte_i == 8'd1) ? PhCheck : PhData;
          end
        end
        PhData: begin
          xor_d  = xor_q ^ byte_i;
          left_d = left_dec;
          if (left_dec == 8'd0) begin
            phase_d = PhCheck;
          end
          res_valid_o     = 1'b1;
          res_o.kind      = KindPayload;
          res_o.data_byte = byte_i;
        end
        default: begin
          phase_d             = PhHunt;
          res_valid_o         = 1'b1;
          res_o.payload_count = len_q;
          if (byte_i == xor_q) begin
            res_o.kind = KindGood;
          end else begin
            errs_d     = errs_q + 8'd1;
            res_o.kind = KindParity;
          end
        end
      endcase
      res_o.parity_errors = errs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q  <= SyncReset;
      phase_q <= PhHunt;
      left_q  <= 8'd0;
      xor_q   <= 8'd0;
      len_q   <= 8'd0;
      errs_q  <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        sync_q <= cfg_wdata_i;
      end
      phase_q <= phase_d;
      left_q  <= left_d;
      xor_q   <= xor_d;
      len_q   <= len_d;
      errs_q  <= errs_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/slxd_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slxd_out_stage
// Result register: holds one result beat while the sink stalls.
// ----------------------------------------------------------------------------
module slxd_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          res_valid_i,
  input  wire slxd_pkg::res_t res_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         data_byte_o,
  output logic [7:0]         payload_count_o,
  output logic [7:0]         parity_errors_o
);
  import slxd_pkg::*;

  logic valid_q, valid_d;
  res_t res_q, res_d;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    if (free_o) begin
      valid_d = res_valid_i;
      res_d   = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = res_q.kind;
  assign data_byte_o     = res_q.data_byte;
  assign payload_count_o = res_q.payload_count;
  assign parity_errors_o = res_q.parity_errors;

endmodule
`default_nettype wire

>>> rtl/slxd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slxd_checker
// Port level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module slxd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] kind_o,
  input wire logic [7:0] data_byte_o,
  input wire logic [7:0] payload_count_o,
  input wire logic [7:0] parity_errors_o
);
  import slxd_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) &&
      $stable(data_byte_o) && $stable(payload_count_o) && $stable(parity_errors_o))
    else $error("result beat changed while stalled");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindPayload |-> payload_count_o == 8'd0)
    else $error("payload beat carries a count");

  a_verdict_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KindPayload |-> data_byte_o == 8'd0)
    else $error("verdict beat carries data");

  a_zero_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KindZero |-> payload_count_o == 8'd0)
    else $error("zero length verdict with nonzero count");

endmodule

bind sync_length_xor_deframer slxd_checker u_slxd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .kind_o          (kind_o),
  .data_byte_o     (data_byte_o),
  .payload_count_o (payload_count_o),
  .parity_errors_o (parity_errors_o)
);
`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sync/length/xor byte stream deframer.
// ----------------------------------------------------------------------------
// A queue of received bytes feeds a valid/stall driver, and a monitor checks
// every output beat against a frame tracker that follows the same hunt,
// length, payload and check rules. The run walks through several sync values
// and starts with hand-picked frames. Random frames follow, with noise and cut
// frames mixed in, plus one frame of maximum length. A burst of short bad
// frames piles up parity errors. Both sides idle at
// random, the receiver holds off once for a long stretch, and one phase runs
// with no idling at all.
module tb;
  import slxd_pkg::*;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] kind_o;
  logic [7:0] data_byte_o;
  logic [7:0] payload_count_o;
  logic [7:0] parity_errors_o;

  sync_length_xor_deframer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .payload_count_o(payload_count_o),
    .parity_errors_o(parity_errors_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [7:0] rx_stream_q[$];
  res_t       deframed_q[$];
  res_t       want_beat;
  int         mismatches   = 0;
  int         framed_items = 0;
  int         hold_reqs    = 0;
  int         hold_seen    = 0;
  int         hold_left    = 0;
  bit         steady       = 1'b0;
  bit         in_took      = 1'b0;
  logic [7:0] stim_sync    = SyncReset;

  // frame tracker state
  logic [7:0] trk_sync  = SyncReset;
  logic [1:0] trk_phase = PhHunt;
  logic [7:0] trk_left  = 8'h00;
  logic [7:0] trk_xor   = 8'h00;
  logic [7:0] trk_plen  = 8'h00;
  logic [7:0] trk_errs  = 8'h00;

  task automatic deframe_byte(input logic [7:0] b);
    res_t r;
    r = '0;
    case (trk_phase)
      PhHunt: begin
        if (b == trk_sync) trk_phase = PhLen;
      end
      PhLen: begin
        trk_xor = 8'h00;
        if (b == 8'h00) begin
          trk_plen = 8'h00;
          trk_left = 8'h00;
          trk_phase = PhHunt;
          r.kind = KindZero;
          r.parity_errors = trk_errs;
          deframed_q.push_back(r);
        end else begin
          trk_plen = b - 8'd1;
          trk_left = trk_plen;
          trk_phase = (trk_left == 8'h00) ? PhCheck : PhData;
        end
      end
      PhData: begin
        trk_xor = trk_xor ^ b;
        if (trk_left != 8'h00) trk_left = trk_left - 8'd1;
        if (trk_left == 8'h00) trk_phase = PhCheck;
        r.kind = KindPayload;
        r.data_byte = b;
        r.parity_errors = trk_errs;
        deframed_q.push_back(r);
      end
      default: begin
        trk_phase = PhHunt;
        if (b == trk_xor) begin
          r.kind = KindGood;
        end else begin
          trk_errs = trk_errs + 8'd1;
          r.kind = KindParity;
        end
        r.payload_count = trk_plen;
        r.parity_errors = trk_errs;
        deframed_q.push_back(r);
      end
    endcase
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (rx_stream_q.size() > 0 && (steady || $urandom_range(0, 99) >= 17)) begin
        in_valid_i <= 1'b1;
        rx_byte_i <= rx_stream_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 80;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(0, 99) < 17);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) deframe_byte(rx_byte_i);
      if (out_valid_o && !out_stall_i) begin
        if (deframed_q.size() == 0) begin
          $error("beat with nothing pending: kind %0d data %0h", kind_o, data_byte_o);
          mismatches++;
        end else begin
          want_beat = deframed_q.pop_front();
          if (kind_o !== want_beat.kind) begin
            $error("kind: expected %0d, got %0d", want_beat.kind, kind_o);
            mismatches++;
          end
          if (data_byte_o !== want_beat.data_byte) begin
            $error("data_byte: expected %0h, got %0h", want_beat.data_byte, data_byte_o);
            mismatches++;
          end
          if (payload_count_o !== want_beat.payload_count) begin
            $error("payload_count: expected %0d, got %0d",
                   want_beat.payload_count, payload_count_o);
            mismatches++;
          end
          if (parity_errors_o !== want_beat.parity_errors) begin
            $error("parity_errors: expected %0d, got %0d",
                   want_beat.parity_errors, parity_errors_o);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic add_frame(input logic [7:0] len, input bit good, input bit cut);
    logic [7:0] acc;
    logic [7:0] pb;
    logic [7:0] flip;
    int n;
    acc = 8'h00;
    n = (len == 8'h00) ? 0 : int'(len) - 1;
    if (cut) n = int'($urandom_range(0, n));
    rx_stream_q.push_back(stim_sync);
    rx_stream_q.push_back(len);
    framed_items += 2;
    for (int i = 0; i < n; i++) begin
      pb = 8'($urandom);
      acc = acc ^ pb;
      rx_stream_q.push_back(pb);
      framed_items++;
    end
    if (len != 8'h00 && !cut) begin
      flip = 8'($urandom_range(1, 255));
      rx_stream_q.push_back(good ? acc : acc ^ flip);
      framed_items++;
    end
  endtask

  task automatic random_frames(input int target);
    int start;
    int r;
    logic [7:0] len;
    logic [7:0] junk;
    start = framed_items;
    while (framed_items - start < target) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          junk = 8'($urandom);
          rx_stream_q.push_back(junk);
        end
      end
      r = int'($urandom_range(0, 99));
      if (r < 8) len = 8'h00;
      else if (r < 75) len = 8'($urandom_range(1, 8));
      else len = 8'($urandom_range(9, 48));
      add_frame(len, $urandom_range(0, 99) < 60, r >= 8 && $urandom_range(0, 99) < 6);
    end
  endtask

  task automatic drain();
    while (rx_stream_q.size() != 0 || in_valid_i || deframed_q.size() != 0)
      @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_sync(input logic [7:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    stim_sync = v;
    trk_sync = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [7:0] opening [23];
    opening = '{
      8'h00, 8'hFF,
      8'hAA, 8'h00,
      8'hAA, 8'h01, 8'h00,
      8'hAA, 8'h01, 8'h5A,
      8'hAA, 8'h03, 8'hFF, 8'h00, 8'hFF,
      8'hAA, 8'h02, 8'hAA, 8'hAA,
      8'hAA, 8'h02, 8'h55, 8'hAA
    };
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (opening[i]) rx_stream_q.push_back(opening[i]);
    drain();

    write_sync(8'h00);
    random_frames(50);
    drain();

    write_sync(8'hFF);
    random_frames(30);
    hold_reqs++;
    add_frame(8'hFF, 1'b1, 1'b0);
    random_frames(30);
    drain();

    write_sync(8'($urandom_range(1, 254)));
    repeat (20) add_frame($urandom_range(0, 9) == 0 ? 8'h02 : 8'h01, 1'b0, 1'b0);
    drain();

    write_sync(SyncReset);
    steady = 1'b1;
    random_frames(60);
    drain();
    steady = 1'b0;

    repeat (8) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
